// ===== design/htfd_pkg.sv =====
// htfd_pkg: shared types, constants and functions of the humidity/temperature frame decoder.
// Holds the word structs, frame position codes, CRC-8 update and the divide-by-65535 helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package htfd_pkg;

	// input word of the byte channel
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_word_t;

	// result word
	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic [7:0]         temperature_crc;
		logic [7:0]         humidity_crc;
		logic               temperature_crc_ok;
		logic               humidity_crc_ok;
	} out_word_t;

	// products and flags handed from the frame stage to the scaling stage
	typedef struct packed {
		logic [30:0] temp_prod;
		logic [29:0] humi_prod;
		logic [7:0]  temp_crc;
		logic [7:0]  humi_crc;
		logic        temp_ok;
		logic        humi_ok;
	} prod_t;

	// frame byte positions
	typedef logic [2:0] pos_t;
	localparam pos_t POS_TEMP_MSB = 3'd0;
	localparam pos_t POS_TEMP_LSB = 3'd1;
	localparam pos_t POS_TEMP_CRC = 3'd2;
	localparam pos_t POS_HUMI_MSB = 3'd3;
	localparam pos_t POS_HUMI_LSB = 3'd4;
	localparam pos_t POS_HUMI_CRC = 3'd5;

	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam logic [7:0]  POLY_RESET  = 8'h31;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [13:0] HUMI_SPAN   = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	// one byte of CRC-8, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(n / 65535) for n < 17500 * 65536: high half plus one correction
	function automatic logic [14:0] div_full_scale(input logic [30:0] n);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = n[30:16];
		r  = {1'b0, n[15:0]} + {2'b00, q0};
		return (r >= FULL_SCALE) ? q0 + 15'd1 : q0;
	endfunction

endpackage
`default_nettype wire

// ===== design/htfd_frame.sv =====
// htfd_frame: input register, frame position tracking, CRC-8 and word capture.
// Hands the two scale products plus CRC results to htfd_scale; uses htfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htfd_frame (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire htfd_pkg::in_word_t in_word,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data,
	input  wire logic              scale_ready,
	output logic                   prod_valid,
	output htfd_pkg::prod_t        prod
);

	logic                valid_s1;
	htfd_pkg::in_word_t  word_s1;
	logic [7:0]          poly_q;
	htfd_pkg::pos_t      pos_q;
	logic [7:0]          crc_q;
	logic [15:0]         temp_word_q;
	logic [15:0]         humi_word_q;
	logic [7:0]          temp_crc_q;
	logic                temp_ok_q;

	htfd_pkg::pos_t      pos_eff;
	logic [7:0]          crc_eff;
	logic [7:0]          crc_upd;
	logic                is_last;
	logic                adv_s1;
	logic                accept;

	// position and crc seen by the byte in s1
	always_comb begin
		if (word_s1.frame_start || pos_q > htfd_pkg::POS_HUMI_CRC) begin
			pos_eff = htfd_pkg::POS_TEMP_MSB;
			crc_eff = htfd_pkg::CRC_INIT;
		end else begin
			pos_eff = pos_q;
			crc_eff = crc_q;
		end
	end

	assign crc_upd   = htfd_pkg::crc8_byte(crc_eff, word_s1.data_byte, poly_q);
	assign is_last   = (pos_eff == htfd_pkg::POS_HUMI_CRC);
	assign adv_s1    = valid_s1 && (!is_last || scale_ready);
	assign in_stall  = valid_s1 && !adv_s1;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// products for the last byte of a frame
	assign prod_valid      = adv_s1 && is_last;
	assign prod.temp_prod  = temp_word_q * htfd_pkg::TEMP_SPAN;
	assign prod.humi_prod  = humi_word_q * htfd_pkg::HUMI_SPAN;
	assign prod.temp_crc   = temp_crc_q;
	assign prod.humi_crc   = crc_eff;
	assign prod.temp_ok    = temp_ok_q;
	assign prod.humi_ok    = (crc_eff == word_s1.data_byte);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	// polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= htfd_pkg::POLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			poly_q <= cfg_data;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= htfd_pkg::POS_TEMP_MSB;
			crc_q       <= htfd_pkg::CRC_INIT;
			temp_word_q <= '0;
			humi_word_q <= '0;
			temp_crc_q  <= '0;
			temp_ok_q   <= 1'b0;
		end else if (adv_s1) begin
			unique case (pos_eff)
				htfd_pkg::POS_TEMP_MSB: begin
					temp_word_q[15:8] <= word_s1.data_byte;
					crc_q             <= crc_upd;
					pos_q             <= htfd_pkg::POS_TEMP_LSB;
				end
				htfd_pkg::POS_TEMP_LSB: begin
					temp_word_q[7:0] <= word_s1.data_byte;
					crc_q            <= crc_upd;
					pos_q            <= htfd_pkg::POS_TEMP_CRC;
				end
				htfd_pkg::POS_TEMP_CRC: begin
					temp_crc_q <= crc_eff;
					temp_ok_q  <= (crc_eff == word_s1.data_byte);
					crc_q      <= htfd_pkg::CRC_INIT;
					pos_q      <= htfd_pkg::POS_HUMI_MSB;
				end
				htfd_pkg::POS_HUMI_MSB: begin
					humi_word_q[15:8] <= word_s1.data_byte;
					crc_q             <= crc_upd;
					pos_q             <= htfd_pkg::POS_HUMI_LSB;
				end
				htfd_pkg::POS_HUMI_LSB: begin
					humi_word_q[7:0] <= word_s1.data_byte;
					crc_q            <= crc_upd;
					pos_q            <= htfd_pkg::POS_HUMI_CRC;
				end
				default: begin
					crc_q <= htfd_pkg::CRC_INIT;
					pos_q <= htfd_pkg::POS_TEMP_MSB;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/htfd_scale.sv =====
// htfd_scale: product register, divide by full scale, temperature offset and result register.
// Takes prod_t words from htfd_frame; uses htfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htfd_scale (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                prod_valid,
	input  wire htfd_pkg::prod_t     prod,
	output logic                     scale_ready,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output htfd_pkg::out_word_t      out_word
);

	logic                 valid_s2;
	htfd_pkg::prod_t      prod_s2;
	logic                 out_valid_q;
	htfd_pkg::out_word_t  out_word_q;
	logic                 adv_s2;
	logic [14:0]          temp_q15;
	logic [14:0]          humi_q15;
	logic [15:0]          temp_signed;

	assign adv_s2      = valid_s2 && (!out_valid_q || !out_stall);
	assign scale_ready = !valid_s2 || adv_s2;

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (prod_valid) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid) begin
			prod_s2 <= prod;
		end
	end

	// scaling to hundredths
	assign temp_q15    = htfd_pkg::div_full_scale(prod_s2.temp_prod);
	assign humi_q15    = htfd_pkg::div_full_scale({1'b0, prod_s2.humi_prod});
	assign temp_signed = {1'b0, temp_q15} - htfd_pkg::TEMP_OFFSET;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_word_q.temperature_centi  <= signed'(temp_signed[14:0]);
			out_word_q.humidity_centi     <= humi_q15[13:0];
			out_word_q.temperature_crc    <= prod_s2.temp_crc;
			out_word_q.humidity_crc       <= prod_s2.humi_crc;
			out_word_q.temperature_crc_ok <= prod_s2.temp_ok;
			out_word_q.humidity_crc_ok    <= prod_s2.humi_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

// ===== design/humidity_temp_frame_decoder_unit.sv =====
// Humidity/temperature frame decoder: takes the six-byte sensor frame one byte per cycle
// (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC), checks both CRC-8 values (init 0xFF,
// msb first, programmable polynomial, reset 0x31) and, on the sixth byte, returns one word
// with temperature and humidity in hundredths plus the computed CRCs and match flags.
// frame_start forces the byte to be byte 0 of a new frame. One byte is accepted every cycle
// while the result side keeps up; the last byte of a frame waits in the input register while
// the product and result registers are full and out_stall is high. The last byte's result
// moves from the input register to the product register, then to the result register.
// The CRC update is an unrolled 8-bit step on the input register.
`timescale 1ns / 1ps
`default_nettype none
module humidity_temp_frame_decoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire htfd_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output htfd_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);

	logic             scale_ready;
	logic             prod_valid;
	htfd_pkg::prod_t  prod;

	// byte tracking and crc
	htfd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.scale_ready (scale_ready),
		.prod_valid  (prod_valid),
		.prod        (prod)
	);

	// scaling and result word
	htfd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.prod_valid  (prod_valid),
		.prod        (prod),
		.scale_ready (scale_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

endmodule
`default_nettype wire

// ===== design/htfd_checker.sv =====
// htfd_checker: port-level checks of the humidity/temperature frame decoder.
// Bound to humidity_temp_frame_decoder_unit; uses htfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htfd_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire htfd_pkg::out_word_t out_word,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// no result and no input stall right after reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid && !in_stall)
		else $error("pipeline not empty out of reset");

	// scaled values stay in range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.temperature_centi >= -15'sd4500 &&
			out_word.temperature_centi <= 15'sd13000)
		else $error("temperature out of range");

	a_humi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.humidity_centi <= 14'd10000)
		else $error("humidity out of range");

	// config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write held off");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== tb/humidity_temp_frame_decoder_unit_tb.sv =====
// Self-checking testbench of the humidity/temperature frame decoder: a directed byte table,
// then random frames, broken frames and noise under several CRC polynomials.
// Depends on htfd_pkg and humidity_temp_frame_decoder_unit; expected words from a predictor.
`timescale 1ns / 1ps
`default_nettype none
module humidity_temp_frame_decoder_unit_tb;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 4;
	localparam int LATENCY_SLACK = 10;
	localparam int LONG_HOLD     = 150;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BYTES   = 130;
	localparam int DIRECTED_ROWS = 26;
	localparam int RUN_LIMIT_NS  = 4_000_000;

	// one table row: the input word, and a typed-in result where one is known by hand
	typedef struct packed {
		htfd_pkg::in_word_t  stim;
		logic                typed;
		htfd_pkg::out_word_t result;
	} row_t;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_HEAVY, RX_TOGGLE} rx_mode_e;

	localparam htfd_pkg::out_word_t NO_RESULT = '0;
	// well-known check value: crc of 0xBEEF is 0x92 under 0x31
	localparam htfd_pkg::out_word_t BEEF_OK   =
		{15'd8552, 14'd7458, 8'h92, 8'h92, 1'b1, 1'b1};
	localparam htfd_pkg::out_word_t BEEF_BAD  =
		{15'd8552, 14'd7458, 8'h92, 8'h92, 1'b0, 1'b0};

	localparam row_t SCRIPT [DIRECTED_ROWS] = '{
		// good frame right after reset
		{8'hBE, 1'b1, 1'b0, NO_RESULT}, {8'hEF, 1'b0, 1'b0, NO_RESULT},
		{8'h92, 1'b0, 1'b0, NO_RESULT}, {8'hBE, 1'b0, 1'b0, NO_RESULT},
		{8'hEF, 1'b0, 1'b0, NO_RESULT}, {8'h92, 1'b0, 1'b1, BEEF_OK},
		// back to back without a start flag, both crc bytes wrong
		{8'hBE, 1'b0, 1'b0, NO_RESULT}, {8'hEF, 1'b0, 1'b0, NO_RESULT},
		{8'h93, 1'b0, 1'b0, NO_RESULT}, {8'hBE, 1'b0, 1'b0, NO_RESULT},
		{8'hEF, 1'b0, 1'b0, NO_RESULT}, {8'h00, 1'b0, 1'b1, BEEF_BAD},
		// partial frame dropped by a start flag
		{8'h00, 1'b1, 1'b0, NO_RESULT}, {8'hAB, 1'b0, 1'b0, NO_RESULT},
		// hottest temperature, driest humidity
		{8'hFF, 1'b1, 1'b0, NO_RESULT}, {8'hFF, 1'b0, 1'b0, NO_RESULT},
		{8'h5A, 1'b0, 1'b0, NO_RESULT}, {8'h00, 1'b0, 1'b0, NO_RESULT},
		{8'h00, 1'b0, 1'b0, NO_RESULT}, {8'hC3, 1'b0, 1'b0, NO_RESULT},
		// coldest temperature, wettest humidity, no start flag
		{8'h00, 1'b0, 1'b0, NO_RESULT}, {8'h00, 1'b0, 1'b0, NO_RESULT},
		{8'hA5, 1'b0, 1'b0, NO_RESULT}, {8'hFF, 1'b0, 1'b0, NO_RESULT},
		{8'hFF, 1'b0, 1'b0, NO_RESULT}, {8'hFF, 1'b0, 1'b0, NO_RESULT}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	htfd_pkg::in_word_t  in_word;
	logic                out_valid;
	logic                out_stall;
	htfd_pkg::out_word_t out_word;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;

	// predictor state
	logic [7:0]     cur_poly;
	htfd_pkg::pos_t dec_pos;
	logic [7:0]     dec_crc;
	logic [15:0]    dec_temp_raw;
	logic [7:0]     dec_temp_crc;
	logic           dec_temp_ok;
	logic [15:0]    dec_humi_raw;

	// stimulus generator view of the frame position
	int unsigned gen_pos;

	row_t                byte_stream[$];
	htfd_pkg::out_word_t frame_results[$];

	logic long_hold;
	int   failures;
	int   frames_checked;
	int   bytes_sent;
	int   polys_used;

	humidity_temp_frame_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// crc-8, one data bit per shift, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ poly;
			end
		end
		return c;
	endfunction

	// advance the decoder model by one accepted word
	task automatic decode_byte(input htfd_pkg::in_word_t w, output logic has,
			output htfd_pkg::out_word_t r);
		htfd_pkg::pos_t pos;
		int             temp_c;
		int             humi_c;
		pos = dec_pos;
		has = 1'b0;
		r   = '0;
		if (w.frame_start || pos > htfd_pkg::POS_HUMI_CRC) begin
			pos     = htfd_pkg::POS_TEMP_MSB;
			dec_crc = htfd_pkg::CRC_INIT;
		end
		case (pos)
			htfd_pkg::POS_TEMP_MSB: begin
				dec_temp_raw[15:8] = w.data_byte;
				dec_crc = crc8_step(dec_crc, w.data_byte, cur_poly);
			end
			htfd_pkg::POS_TEMP_LSB: begin
				dec_temp_raw[7:0] = w.data_byte;
				dec_crc = crc8_step(dec_crc, w.data_byte, cur_poly);
			end
			htfd_pkg::POS_TEMP_CRC: begin
				dec_temp_crc = dec_crc;
				dec_temp_ok  = (dec_crc == w.data_byte);
				dec_crc      = htfd_pkg::CRC_INIT;
			end
			htfd_pkg::POS_HUMI_MSB: begin
				dec_humi_raw[15:8] = w.data_byte;
				dec_crc = crc8_step(dec_crc, w.data_byte, cur_poly);
			end
			htfd_pkg::POS_HUMI_LSB: begin
				dec_humi_raw[7:0] = w.data_byte;
				dec_crc = crc8_step(dec_crc, w.data_byte, cur_poly);
			end
			default: begin
				temp_c = int'(dec_temp_raw) * int'(htfd_pkg::TEMP_SPAN)
					/ int'(htfd_pkg::FULL_SCALE) - int'(htfd_pkg::TEMP_OFFSET);
				humi_c = int'(dec_humi_raw) * int'(htfd_pkg::HUMI_SPAN)
					/ int'(htfd_pkg::FULL_SCALE);
				r.temperature_centi  = temp_c[14:0];
				r.humidity_centi     = humi_c[13:0];
				r.temperature_crc    = dec_temp_crc;
				r.humidity_crc       = dec_crc;
				r.temperature_crc_ok = dec_temp_ok;
				r.humidity_crc_ok    = (dec_crc == w.data_byte);
				has     = 1'b1;
				dec_crc = htfd_pkg::CRC_INIT;
			end
		endcase
		dec_pos = has ? htfd_pkg::POS_TEMP_MSB : pos + 3'd1;
	endtask

	// offer one word, hold it until taken, then predict
	task automatic send_row(input row_t r);
		logic                has;
		htfd_pkg::out_word_t res;
		in_word  <= r.stim;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		decode_byte(r.stim, has, res);
		if (has) begin
			frame_results.push_back(r.typed ? r.result : res);
		end
	endtask

	// drain the byte stream in bursts with random gaps
	task automatic send_stream();
		int burst;
		int gap;
		while (byte_stream.size() != 0) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			for (int k = 0; k < burst && byte_stream.size() != 0; k++) begin
				send_row(byte_stream.pop_front());
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// wait for every pending frame, then let the pipeline settle
	task automatic wait_idle();
		while (frame_results.size() != 0) @(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	task automatic write_poly(input logic [7:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_poly = value;
		polys_used++;
	endtask

	// queue one word and track where the block will be in its frame
	task automatic push_byte(input logic [7:0] b, input logic s);
		row_t r;
		r = '0;
		r.stim.data_byte   = b;
		r.stim.frame_start = s;
		byte_stream.push_back(r);
		gen_pos = s ? 1 : (gen_pos >= 5 ? 0 : gen_pos + 1);
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly well-formed frames, some cut short, some noise
	task automatic gen_phase(input int count);
		logic [15:0] t_raw;
		logic [15:0] h_raw;
		logic [7:0]  frame [6];
		logic        s;
		int          len;
		int          pick;
		while (byte_stream.size() < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				t_raw = pick_raw();
				h_raw = pick_raw();
				frame[0] = t_raw[15:8];
				frame[1] = t_raw[7:0];
				frame[2] = crc8_step(crc8_step(htfd_pkg::CRC_INIT, frame[0], cur_poly),
					frame[1], cur_poly);
				frame[3] = h_raw[15:8];
				frame[4] = h_raw[7:0];
				frame[5] = crc8_step(crc8_step(htfd_pkg::CRC_INIT, frame[3], cur_poly),
					frame[4], cur_poly);
				if ($urandom_range(0, 3) == 0) frame[2] = 8'($urandom);
				if ($urandom_range(0, 3) == 0) frame[5] = 8'($urandom);
				s   = (gen_pos != 0) || ($urandom_range(0, 1) == 1);
				len = (pick < 70) ? 6 : $urandom_range(1, 5);
				for (int i = 0; i < len; i++) begin
					push_byte(frame[i], (i == 0) ? s : 1'b0);
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					push_byte(8'($urandom), $urandom_range(0, 5) == 0);
				end
			end
		end
	endtask

	// receiver stall pattern, with one long hold-off on request
	initial begin
		rx_mode_e mode;
		int       len;
		logic     toggle;
		logic     hold_done;
		toggle    = 1'b0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			mode = rx_mode_e'($urandom_range(0, 3));
			len  = $urandom_range(20, 80);
			repeat (len) begin
				@(posedge clk);
				if (long_hold && !hold_done) begin
					out_stall <= 1'b1;
					repeat (LONG_HOLD - 1) @(posedge clk);
					hold_done = 1'b1;
				end else begin
					toggle = ~toggle;
					case (mode)
						RX_FREE:   out_stall <= 1'b0;
						RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
						RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 8);
						default:   out_stall <= toggle;
					endcase
				end
			end
		end
	end

	// compare each taken result word with the oldest prediction
	always @(posedge clk) begin
		htfd_pkg::out_word_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_results.size() == 0) begin
				$error("result word with no frame pending: %h", out_word);
				failures++;
			end else begin
				exp_w = frame_results.pop_front();
				frames_checked++;
				if (out_word.temperature_centi !== exp_w.temperature_centi) begin
					$error("temperature_centi: expected %0d, got %0d",
						exp_w.temperature_centi, out_word.temperature_centi);
					failures++;
				end
				if (out_word.humidity_centi !== exp_w.humidity_centi) begin
					$error("humidity_centi: expected %0d, got %0d",
						exp_w.humidity_centi, out_word.humidity_centi);
					failures++;
				end
				if (out_word.temperature_crc !== exp_w.temperature_crc) begin
					$error("temperature_crc: expected %h, got %h",
						exp_w.temperature_crc, out_word.temperature_crc);
					failures++;
				end
				if (out_word.humidity_crc !== exp_w.humidity_crc) begin
					$error("humidity_crc: expected %h, got %h",
						exp_w.humidity_crc, out_word.humidity_crc);
					failures++;
				end
				if (out_word.temperature_crc_ok !== exp_w.temperature_crc_ok) begin
					$error("temperature_crc_ok: expected %b, got %b",
						exp_w.temperature_crc_ok, out_word.temperature_crc_ok);
					failures++;
				end
				if (out_word.humidity_crc_ok !== exp_w.humidity_crc_ok) begin
					$error("humidity_crc_ok: expected %b, got %b",
						exp_w.humidity_crc_ok, out_word.humidity_crc_ok);
					failures++;
				end
			end
		end
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	// main sequence
	initial begin
		logic [7:0] phase_poly [RANDOM_PHASES];
		phase_poly[0] = 8'h00;
		phase_poly[1] = 8'hFF;
		phase_poly[2] = 8'h07;
		phase_poly[3] = 8'($urandom_range(1, 254));
		phase_poly[4] = htfd_pkg::POLY_RESET;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		long_hold = 1'b0;
		failures       = 0;
		frames_checked = 0;
		bytes_sent     = 0;
		polys_used     = 1;
		gen_pos        = 0;

		// predictor reset
		cur_poly     = htfd_pkg::POLY_RESET;
		dec_pos      = htfd_pkg::POS_TEMP_MSB;
		dec_crc      = htfd_pkg::CRC_INIT;
		dec_temp_raw = '0;
		dec_temp_crc = '0;
		dec_temp_ok  = 1'b0;
		dec_humi_raw = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset polynomial
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			byte_stream.push_back(SCRIPT[i]);
		end
		gen_pos = 0;
		send_stream();
		wait_idle();

		// random phases, one polynomial each; phases may end mid-frame
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_poly(phase_poly[p]);
			gen_phase(PHASE_BYTES);
			if (p == 2) begin
				long_hold <= 1'b1;
			end
			send_stream();
			wait_idle();
		end

		if (frame_results.size() != 0) begin
			$error("%0d expected frames never came out", frame_results.size());
			failures++;
		end
		$display("run covered %0d input words and %0d checked frames under %0d crc polynomials,",
			bytes_sent, frames_checked, polys_used);
		$display("with bad crc bytes, truncated frames, restarts and a long output hold-off");
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
